// ----- design/irmc_pkg.sv -----
// shared types, constants and codes of the irrigation mode controller
package irmc_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int PCT_BITS        = 7;
    localparam int TIME_BITS       = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOISTURE_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IRRIGATION_SECONDS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL_MS    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOIL_DRY_COUNT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOIL_WET_COUNT     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TANK_EMPTY_COUNT   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TANK_FULL_COUNT    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WATER_THRESHOLD    = 3'd7;

    // mode codes
    localparam logic [2:0] MODE_INIT     = 3'd0;
    localparam logic [2:0] MODE_MONITOR  = 3'd1;
    localparam logic [2:0] MODE_CHECK    = 3'd2;
    localparam logic [2:0] MODE_IRRIGATE = 3'd3;
    localparam logic [2:0] MODE_BLOCKED  = 3'd4;
    localparam logic [2:0] MODE_WAITING  = 3'd5;

    // action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_MONITOR = 3'd1;
    localparam logic [2:0] ACT_CHECK   = 3'd2;
    localparam logic [2:0] ACT_START   = 3'd3;
    localparam logic [2:0] ACT_FINISH  = 3'd4;
    localparam logic [2:0] ACT_BLOCK   = 3'd5;
    localparam logic [2:0] ACT_WAIT    = 3'd6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] moisture_sample;
        logic [SAMPLE_BITS-1:0] level_sample;
        logic [TIME_BITS-1:0]   now_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]          mode;
        logic [2:0]          action;
        logic                pump_on;
        logic [PCT_BITS-1:0] moisture_percent;
        logic [PCT_BITS-1:0] level_percent;
        logic                water_present;
    } t_result;

    typedef struct packed {
        logic [PCT_BITS-1:0]    moisture_limit;
        logic [5:0]             irrigation_seconds;
        logic [19:0]            min_interval_ms;
        logic [SAMPLE_BITS-1:0] soil_dry_count;
        logic [SAMPLE_BITS-1:0] soil_wet_count;
        logic [SAMPLE_BITS-1:0] tank_empty_count;
        logic [SAMPLE_BITS-1:0] tank_full_count;
        logic [SAMPLE_BITS-1:0] water_threshold;
    } t_cfg;

    // classified period between front and back
    typedef struct packed {
        logic [PCT_BITS-1:0]  moisture_percent;
        logic [PCT_BITS-1:0]  level_percent;
        logic                 water_present;
        logic [TIME_BITS-1:0] now_ms;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam t_cfg CFG_RESET = '{
        moisture_limit:     PCT_BITS'(40),
        irrigation_seconds: 6'd10,
        min_interval_ms:    20'd30000,
        soil_dry_count:     SAMPLE_BITS'(3200),
        soil_wet_count:     SAMPLE_BITS'(1300),
        tank_empty_count:   SAMPLE_BITS'(100),
        tank_full_count:    SAMPLE_BITS'(2600),
        water_threshold:    SAMPLE_BITS'(700)
    };

endpackage

// ----- design/irmc_front.sv -----
// front end: takes a period, maps both samples to percent, flags water
module irmc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  irmc_pkg::t_cfg  i_cfg,
    input  logic            push,
    input  irmc_pkg::t_item i_item,
    output logic            full,
    input  irmc_pkg::t_qstat i_qstat,
    output logic            o_q_push,
    output irmc_pkg::t_cls  o_q_data
);
    import irmc_pkg::*;

    localparam int REM_W = SAMPLE_BITS + PCT_BITS;
    localparam int DSH_W = SAMPLE_BITS + PCT_BITS - 1;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_PUSH} t_state;

    t_state               r_state;
    t_item                r_item;
    logic                 r_chan;
    logic [REM_W-1:0]     r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [PCT_BITS-2:0]  r_q;
    logic [2:0]           r_step;
    logic [PCT_BITS-1:0]  r_mp;
    logic [PCT_BITS-1:0]  r_lp;

    logic [SAMPLE_BITS-1:0] sel_x, sel_p0, sel_p100;
    logic signed [SAMPLE_BITS:0] diff, den;
    logic [SAMPLE_BITS:0]   neg_diff, neg_den;
    logic [SAMPLE_BITS-1:0] adiff, aden;
    logic                   ld_zero, ld_full;
    logic [REM_W-1:0]       ld_prod;
    logic                   div_bit;
    logic                   fin;
    logic [PCT_BITS-1:0]    fin_val;

    always_comb begin
        sel_x    = r_chan ? r_item.level_sample : r_item.moisture_sample;
        sel_p0   = r_chan ? i_cfg.tank_empty_count : i_cfg.soil_dry_count;
        sel_p100 = r_chan ? i_cfg.tank_full_count : i_cfg.soil_wet_count;
        diff     = $signed({1'b0, sel_x}) - $signed({1'b0, sel_p0});
        den      = $signed({1'b0, sel_p100}) - $signed({1'b0, sel_p0});
        neg_diff = ~diff + 1'b1;
        neg_den  = ~den + 1'b1;
        adiff    = diff[SAMPLE_BITS] ? neg_diff[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
        aden     = den[SAMPLE_BITS] ? neg_den[SAMPLE_BITS-1:0] : den[SAMPLE_BITS-1:0];
        ld_zero  = (den == '0) || (diff == '0) || (diff[SAMPLE_BITS] != den[SAMPLE_BITS]);
        ld_full  = adiff >= aden;
        ld_prod  = REM_W'(adiff) * REM_W'(100);
        div_bit  = r_rem >= REM_W'(r_dsh);

        fin     = 1'b0;
        fin_val = '0;
        case (r_state)
            S_LOAD: begin
                fin     = ld_zero || ld_full;
                fin_val = ld_zero ? '0 : PCT_FULL;
            end
            S_DIV: begin
                fin     = (r_step == '0);
                fin_val = {r_q, div_bit};
            end
            default: begin
                fin     = 1'b0;
                fin_val = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (push) begin
                        r_item  <= i_item;
                        r_chan  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD, S_DIV: begin
                    if (r_state == S_LOAD && !fin) begin
                        r_rem   <= ld_prod;
                        r_dsh   <= {aden, {(PCT_BITS-1){1'b0}}};
                        r_q     <= '0;
                        r_step  <= 3'(PCT_BITS - 1);
                        r_state <= S_DIV;
                    end else if (r_state == S_DIV && !fin) begin
                        if (div_bit) begin
                            r_rem <= r_rem - REM_W'(r_dsh);
                        end
                        r_q    <= {r_q[PCT_BITS-3:0], div_bit};
                        r_dsh  <= r_dsh >> 1;
                        r_step <= r_step - 3'd1;
                    end else if (!r_chan) begin
                        r_mp    <= fin_val;
                        r_chan  <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_lp    <= fin_val;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_qstat.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign full     = (r_state != S_IDLE);
    assign o_q_push = (r_state == S_PUSH) && !i_qstat.full;
    assign o_q_data = '{
        moisture_percent: r_mp,
        level_percent:    r_lp,
        water_present:    (r_item.level_sample >= i_cfg.water_threshold),
        now_ms:           r_item.now_ms
    };

endmodule

// ----- design/irmc_queue.sv -----
// small queue of classified periods between front and back
module irmc_queue #(
    parameter int DEPTH = irmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  irmc_pkg::t_cls   i_data,
    input  logic             i_pop,
    output irmc_pkg::t_cls   o_data,
    output irmc_pkg::t_qstat o_stat
);
    import irmc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/irmc_back.sv -----
// back end: mode controller step, timers, pump and result register
module irmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irmc_pkg::t_cfg    i_cfg,
    input  irmc_pkg::t_qstat  i_qstat,
    input  irmc_pkg::t_cls    i_q_data,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output irmc_pkg::t_result o_result
);
    import irmc_pkg::*;

    typedef enum logic [2:0] {
        M_INIT     = MODE_INIT,
        M_MONITOR  = MODE_MONITOR,
        M_CHECK    = MODE_CHECK,
        M_IRRIGATE = MODE_IRRIGATE,
        M_BLOCKED  = MODE_BLOCKED,
        M_WAITING  = MODE_WAITING
    } t_mode;

    t_mode                r_mode;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_last_end;
    logic                 r_pump;
    logic                 r_valid;
    t_result              r_res;

    logic                 take;
    logic                 dry, gap_done, run_done;
    logic [15:0]          run_ms;
    logic [TIME_BITS-1:0] since_end, since_start;
    t_mode                n_mode;
    logic [2:0]           n_act;
    logic                 n_pump;

    always_comb begin
        take        = !i_qstat.empty && (!r_valid || pop);
        dry         = i_q_data.moisture_percent < i_cfg.moisture_limit;
        since_end   = i_q_data.now_ms - r_last_end;
        since_start = i_q_data.now_ms - r_start;
        gap_done    = since_end >= TIME_BITS'(i_cfg.min_interval_ms);
        run_ms      = 16'(i_cfg.irrigation_seconds) * 16'd1000;
        run_done    = since_start >= TIME_BITS'(run_ms);

        n_mode = r_mode;
        n_act  = ACT_NONE;
        unique case (r_mode)
            M_MONITOR: begin
                if (dry && gap_done) begin
                    n_mode = M_CHECK;
                    n_act  = ACT_CHECK;
                end else if (dry) begin
                    n_mode = M_WAITING;
                    n_act  = ACT_WAIT;
                end else begin
                    n_mode = M_MONITOR;
                    n_act  = ACT_MONITOR;
                end
            end
            M_CHECK: begin
                if (i_q_data.water_present) begin
                    n_mode = M_IRRIGATE;
                    n_act  = ACT_START;
                end else begin
                    n_mode = M_BLOCKED;
                    n_act  = ACT_BLOCK;
                end
            end
            M_IRRIGATE: begin
                if (!i_q_data.water_present) begin
                    n_mode = M_BLOCKED;
                    n_act  = ACT_BLOCK;
                end else if (run_done) begin
                    n_mode = M_MONITOR;
                    n_act  = ACT_FINISH;
                end
            end
            M_BLOCKED: begin
                if (i_q_data.water_present) begin
                    n_mode = M_MONITOR;
                    n_act  = ACT_MONITOR;
                end else begin
                    n_mode = M_BLOCKED;
                    n_act  = ACT_BLOCK;
                end
            end
            M_WAITING: begin
                if (!dry) begin
                    n_mode = M_MONITOR;
                    n_act  = ACT_MONITOR;
                end else if (gap_done) begin
                    n_mode = M_CHECK;
                    n_act  = ACT_CHECK;
                end
            end
            default: begin
                n_mode = M_MONITOR;
                n_act  = ACT_MONITOR;
            end
        endcase

        if (n_act == ACT_START) begin
            n_pump = 1'b1;
        end else if (n_act == ACT_NONE) begin
            n_pump = r_pump;
        end else begin
            n_pump = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_INIT;
            r_start    <= '0;
            r_last_end <= '0;
            r_pump     <= 1'b0;
            r_valid    <= 1'b0;
        end else if (take) begin
            r_mode  <= n_mode;
            r_pump  <= n_pump;
            r_valid <= 1'b1;
            if (n_act == ACT_START) begin
                r_start <= i_q_data.now_ms;
            end
            if (n_act == ACT_FINISH || n_act == ACT_BLOCK) begin
                r_last_end <= i_q_data.now_ms;
            end
            r_res <= '{
                mode:             n_mode,
                action:           n_act,
                pump_on:          n_pump,
                moisture_percent: i_q_data.moisture_percent,
                level_percent:    i_q_data.level_percent,
                water_present:    i_q_data.water_present
            };
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_q_pop  = take;
    assign empty    = !r_valid;
    assign o_result = r_res;

endmodule

// ----- design/irrigation_mode_controller.sv -----
// irrigation mode controller top level: config registers, front, queue, back
//
// Each input item is one evaluation period (moisture sample, level sample,
// millisecond time); each gives exactly one result item (mode, action, pump
// drive, both percents, water flag).
// Input side: an item transfers at a clock edge with push high and full low.
// Result side: the oldest result sits on o_result while empty is low and
// transfers at a clock edge with pop high and empty low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once;
// write only while no item is in flight.
// The front end takes one item at a time: per percent map a setup step and
// a 7-step restoring division (skipped when the map clamps), then one queue
// write; it takes no new item until that write is accepted by the queue.
// The back end loads the oldest queued item into its result register when
// that register is empty or is being popped in the same cycle.
// A stalled receiver fills the result register, then the queue; the front end
// then holds its finished item and full stays high.
// Synchronous reset empties the queue and result register, sets mode to
// initializing, clears both timestamps, turns the pump off and reloads the
// configuration defaults.
module irrigation_mode_controller #(
    parameter int QUEUE_DEPTH = irmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [irmc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [irmc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 push,
    input  irmc_pkg::t_item                      i_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output irmc_pkg::t_result                    o_result
);
    import irmc_pkg::*;

    t_cfg   r_cfg;
    t_qstat q_stat;
    t_cls   q_in, q_out;
    logic   q_push, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOISTURE_LIMIT:     r_cfg.moisture_limit     <= i_cfg_data[PCT_BITS-1:0];
                CFG_IRRIGATION_SECONDS: r_cfg.irrigation_seconds <= i_cfg_data[5:0];
                CFG_MIN_INTERVAL_MS:    r_cfg.min_interval_ms    <= i_cfg_data[19:0];
                CFG_SOIL_DRY_COUNT:     r_cfg.soil_dry_count     <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_SOIL_WET_COUNT:     r_cfg.soil_wet_count     <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_TANK_EMPTY_COUNT:   r_cfg.tank_empty_count   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_TANK_FULL_COUNT:    r_cfg.tank_full_count    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_WATER_THRESHOLD:    r_cfg.water_threshold    <= i_cfg_data[SAMPLE_BITS-1:0];
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    irmc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .i_qstat  (q_stat),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    irmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    irmc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (q_stat),
        .i_q_data (q_out),
        .o_q_pop  (q_pop),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    a_pump_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.pump_on == (o_result.mode == MODE_IRRIGATE)))
        else $error("pump drive disagrees with irrigate mode");

    a_start_needs_water: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.action == ACT_START) |-> o_result.water_present)
        else $error("irrigation started without water");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.moisture_percent <= PCT_FULL &&
                    o_result.level_percent <= PCT_FULL))
        else $error("percent above one hundred");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before transfer");

endmodule
